[rtl/sorted_priority_ready_queue_unit_macros.svh]
// assertion macros for the sorted priority ready queue
`ifndef SORTED_PRIORITY_READY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_READY_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("spq assertion failed");
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");
`else
`define SPQ_ASSERT(lbl, clk, rst_n, prop)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/spq_pkg.sv]
`timescale 1ns / 1ps
package spq_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int FUNC_W    = 2;
    localparam int PRIO_W    = 16;
    localparam int ID_W      = 16;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 6;

    localparam logic [FUNC_W-1:0] OP_ENQ = 2'd0;
    localparam logic [FUNC_W-1:0] OP_DEQ = 2'd1;
    localparam logic [FUNC_W-1:0] OP_REM = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] SEL_KEEP  = 2'd0;
    localparam logic [1:0] SEL_LEFT  = 2'd1;
    localparam logic [1:0] SEL_RIGHT = 2'd2;
    localparam logic [1:0] SEL_NEW   = 2'd3;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } t_entry;

    typedef struct packed {
        logic              enq;
        logic              rem;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } t_chain_ctl;

endpackage

[rtl/spq_cell.sv]
`timescale 1ns / 1ps
module spq_cell
    import spq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_valid,
    input  logic [PRIO_W-1:0] i_key_prio,
    input  logic [ID_W-1:0]   i_key_id,
    input  logic [1:0]        i_sel,
    input  t_entry            i_left,
    input  t_entry            i_right,
    input  t_entry            i_new,
    output t_entry            o_entry,
    output logic              o_ge,
    output logic              o_match
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        unique case (i_sel)
            SEL_KEEP:  n_entry = r_entry;
            SEL_LEFT:  n_entry = i_left;
            SEL_RIGHT: n_entry = i_right;
            SEL_NEW:   n_entry = i_new;
            default:   n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_ge    = i_valid && (r_entry.prio >= i_key_prio);
    assign o_match = i_valid && (r_entry.id == i_key_id);

endmodule

[rtl/spq_chain.sv]
`timescale 1ns / 1ps
module spq_chain
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic [CW-1:0]   i_count,
    input  t_chain_ctl      i_ctl,
    output logic            o_found,
    output logic [ID_W-1:0] o_tail_id
);

    t_entry             w_entry [DEPTH];
    logic [DEPTH-1:0]   w_ge;
    logic [DEPTH-1:0]   w_match;
    logic [DEPTH-1:0]   w_pre;
    logic [CW-1:0]      w_tail;
    t_entry             w_new;

    assign w_new.prio = i_ctl.prio;
    assign w_new.id   = i_ctl.id;

    // cells from the lowest match upward
    assign w_pre   = w_match | ((~w_match) + {{(DEPTH-1){1'b0}}, 1'b1});
    assign o_found = |w_match;
    assign w_tail  = i_count - {{(CW-1){1'b0}}, 1'b1};
    assign o_tail_id = w_entry[w_tail[IW-1:0]].id;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CW-1:0] POS  = CW'(i);
        localparam logic [CW-1:0] POS1 = CW'(i + 1);

        logic   w_valid;
        logic   w_ge_prev;
        logic   w_next_valid;
        logic [1:0] w_sel;
        t_entry w_left;
        t_entry w_right;

        assign w_valid      = POS < i_count;
        assign w_next_valid = POS1 < i_count;

        if (i == 0) begin : g_first
            assign w_ge_prev = 1'b0;
            assign w_left    = '0;
        end else begin : g_mid
            assign w_ge_prev = w_ge[i-1];
            assign w_left    = w_entry[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[i+1];
        end

        always_comb begin
            w_sel = SEL_KEEP;
            if (i_ctl.enq && POS <= i_count) begin
                if (w_ge_prev) begin
                    w_sel = SEL_LEFT;
                end else if (w_ge[i] || POS == i_count) begin
                    w_sel = SEL_NEW;
                end
            end else if (i_ctl.rem && w_pre[i] && w_next_valid) begin
                w_sel = SEL_RIGHT;
            end
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_valid    (w_valid),
            .i_key_prio (i_ctl.prio),
            .i_key_id   (i_ctl.id),
            .i_sel      (w_sel),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_new      (w_new),
            .o_entry    (w_entry[i]),
            .o_ge       (w_ge[i]),
            .o_match    (w_match[i])
        );
    end

endmodule

[rtl/sorted_priority_ready_queue_unit.sv]
// channel | handshake                 | words
// in      | i_in_valid / o_in_ready   | i_func, i_priority_req, i_task_id
// out     | o_out_valid / i_out_ready | o_status, o_out_id, o_count
//
// one cycle per word: the cell row shifts on the accept edge, result is
// registered and shows on the next cycle
// a new word is taken while the result register is empty or being drained
// synchronous active-low reset empties the queue and the result register
// an output stall holds the result and blocks the input until taken
`timescale 1ns / 1ps
`include "sorted_priority_ready_queue_unit_macros.svh"
module sorted_priority_ready_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [PRIO_W-1:0]    i_priority_req,
    input  logic [ID_W-1:0]      i_task_id,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic [ID_W-1:0]      o_out_id,
    output logic [CNT_OUT_W-1:0] o_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE      = CW'(1);

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_status;
    logic [STAT_W-1:0]    n_status;
    logic [ID_W-1:0]      r_out_id;
    logic [ID_W-1:0]      n_out_id;
    logic [CNT_OUT_W-1:0] r_out_count;
    logic [CW+CNT_OUT_W-1:0] w_cnt_ext;

    logic            w_acc;
    logic            w_empty;
    logic            w_full;
    logic            w_found;
    logic [ID_W-1:0] w_tail_id;
    t_chain_ctl      w_ctl;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_empty    = r_count == '0;
    assign w_full     = r_count >= FULL_CNT;

    assign w_ctl.enq  = w_acc && i_func == OP_ENQ && !w_full;
    assign w_ctl.rem  = w_acc && i_func == OP_REM && !w_empty;
    assign w_ctl.prio = i_priority_req;
    assign w_ctl.id   = i_task_id;

    spq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .IW    (IW)
    ) u_chain (
        .i_clk     (i_clk),
        .i_count   (r_count),
        .i_ctl     (w_ctl),
        .o_found   (w_found),
        .o_tail_id (w_tail_id)
    );

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_out_id = '0;
        unique case (i_func)
            OP_ENQ: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + ONE;
                end
            end
            OP_DEQ: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count  = r_count - ONE;
                    n_out_id = w_tail_id;
                end
            end
            OP_REM: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_count  = r_count - ONE;
                    n_out_id = i_task_id;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign w_cnt_ext = (CW + CNT_OUT_W)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status    <= n_status;
            r_out_id    <= n_out_id;
            r_out_count <= w_cnt_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_id    = r_out_id;
    assign o_count     = r_out_count;

    `SPQ_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= FULL_CNT)
    `SPQ_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n,
        w_acc && i_func == OP_ENQ && w_full, r_count == FULL_CNT)
    `SPQ_ASSERT_NEXT(a_enq_grows, i_clk, i_rst_n,
        w_acc && i_func == OP_ENQ && !w_full, r_count == $past(r_count) + ONE)
    `SPQ_ASSERT_NEXT(a_deq_shrinks, i_clk, i_rst_n,
        w_acc && i_func == OP_DEQ && !w_empty, r_count == $past(r_count) - ONE)
    `SPQ_ASSERT_NEXT(a_rem_shrinks, i_clk, i_rst_n,
        w_acc && i_func == OP_REM && !w_empty && w_found,
        r_count == $past(r_count) - ONE)
    `SPQ_ASSERT(a_empty_zero, i_clk, i_rst_n,
        !(r_out_valid && r_status == ST_EMPTY) || (r_out_count == '0 && r_out_id == '0))

endmodule
